// File: hdl/ibd_pkg.sv
// shared types, constants and helpers for the iec 61937 burst deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ibd_pkg;

    // default size of the downstream burst buffer in bytes
    localparam int BufferBytesDefault = 8192;

    // depth of the result queue between the deframer and the output port
    localparam int ResultFifoDepth = 4;

    // preamble sync bytes, Pa then Pb, little-endian
    localparam logic [7:0] PaLo = 8'h72;
    localparam logic [7:0] PaHi = 8'hf8;
    localparam logic [7:0] PbLo = 8'h1f;
    localparam logic [7:0] PbHi = 8'h4e;

    // configuration register indexes
    localparam logic [1:0] RegBurstType  = 2'd0;
    localparam logic [1:0] RegMaxPayload = 2'd1;

    // configuration reset values
    localparam logic [4:0]  BurstTypeReset  = 5'd21;
    localparam logic [15:0] MaxPayloadReset = 16'd8184;

    // one result item
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        last_of_burst;
        logic [31:0] resync_total;
        logic [31:0] rejected_total;
        logic [31:0] emitted_total;
    } t_result;

    // status the result queue reports back to the deframer
    typedef struct packed {
        logic nonempty;
        logic pair_room;
    } t_fifo_status;

    // saturating increment of a 32-bit counter
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hffff_ffff) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ibd_result_fifo.sv
// small result queue: takes a pair of result items per cycle, gives one per cycle
// depends on ibd_pkg for the result and status types
`timescale 1ns / 1ps
`default_nettype none

module ibd_result_fifo
    import ibd_pkg::*;
#(
    parameter int DEPTH = ResultFifoDepth
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push_pair,
    input  wire t_result      i_first,
    input  wire t_result      i_second,
    input  wire logic         i_pop,
    output t_result           o_head,
    output t_fifo_status      o_status
);

    localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountW = $clog2(DEPTH + 1);

    t_result               r_mem [DEPTH];
    logic [PtrW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [CountW-1:0]     r_count, n_count;
    logic [PtrW-1:0]       wr_second;
    logic                  pop_ok;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
    endfunction

    // pointer and fill bookkeeping
    always_comb begin
        pop_ok    = i_pop && (r_count != '0);
        wr_second = ptr_inc(r_wr_ptr);
        n_wr_ptr  = i_push_pair ? ptr_inc(wr_second) : r_wr_ptr;
        n_rd_ptr  = pop_ok ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count   = r_count + (i_push_pair ? CountW'(2) : '0) - (pop_ok ? CountW'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, two entries written per push
    always_ff @(posedge i_clk) begin
        if (i_push_pair) begin
            r_mem[r_wr_ptr]  <= i_first;
            r_mem[wr_second] <= i_second;
        end
    end

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.nonempty  = (r_count != '0);
    assign o_status.pair_room = (r_count <= CountW'(DEPTH - 2));

endmodule

`default_nettype wire

// File: hdl/iec61937_burst_deframer_core.sv
// results: the second byte of a pair puts both result items in the output queue in the cycle after it is accepted
// throughput: one carrier item per cycle; a byte pair gives two result items, drained at one
// per cycle through a 4-entry result queue; input stalls while three or more items wait there
// reset: synchronous active low; hunting with an empty window, counters zero,
// burst type 21 and payload limit 8184
// depends on ibd_pkg and ibd_result_fifo
`timescale 1ns / 1ps
`default_nettype none

module iec61937_burst_deframer_core
    import ibd_pkg::*;
#(
    parameter int BUFFER_BYTES = BufferBytesDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // carrier input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_carrier_byte,
    // result output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_payload_byte,
    output logic             o_last_of_burst,
    output logic [31:0]      o_resync_total,
    output logic [31:0]      o_rejected_total,
    output logic [31:0]      o_emitted_total,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam logic [15:0] LenCap = 16'(BUFFER_BYTES - 8);

    // configuration
    logic [4:0]   r_burst_type;
    logic [15:0]  r_max_payload;

    // deframer state
    logic [7:0]   r_window [8];
    logic [7:0]   n_window [8];
    logic [3:0]   r_fill, n_fill;
    logic         r_in_payload, n_in_payload;
    logic [15:0]  r_left, n_left;
    logic [7:0]   r_held, n_held;
    logic [31:0]  r_resync, n_resync;
    logic [31:0]  r_rejected, n_rejected;
    logic [31:0]  r_emitted, n_emitted;

    logic [7:0]   win [8];
    logic [15:0]  pd;
    logic [15:0]  len_limit;
    logic         in_accept;
    logic         push_pair;
    logic         last;
    t_result      res_first, res_second, head;
    t_fifo_status fifo_status;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = !fifo_status.pair_room;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_type  <= BurstTypeReset;
            r_max_payload <= MaxPayloadReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == RegBurstType) begin
                r_burst_type <= i_cfg_data[4:0];
            end else if (i_cfg_index == RegMaxPayload) begin
                r_max_payload <= i_cfg_data;
            end
        end
    end

    assign len_limit = (r_max_payload < LenCap) ? r_max_payload : LenCap;

    // window with the new byte placed at the fill position
    always_comb begin
        win = r_window;
        win[r_fill[2:0]] = i_carrier_byte;
        pd = {win[7], win[6]};
    end

    // hunt and payload step
    always_comb begin
        n_window     = r_window;
        n_fill       = r_fill;
        n_in_payload = r_in_payload;
        n_left       = r_left;
        n_held       = r_held;
        n_resync     = r_resync;
        n_rejected   = r_rejected;
        n_emitted    = r_emitted;
        push_pair    = 1'b0;
        last         = 1'b0;
        if (in_accept) begin
            if (!r_in_payload) begin
                n_window = win;
                n_fill   = r_fill + 4'd1;
                if (r_fill == 4'd7) begin
                    if (win[0] != PaLo || win[1] != PaHi) begin
                        // no preamble at the front: drop one byte
                        n_resync = sat_inc(r_resync);
                        for (int i = 0; i < 7; i++) begin
                            n_window[i] = win[i+1];
                        end
                        n_fill = 4'd7;
                    end else if (win[2] != PbLo || win[3] != PbHi) begin
                        // pa alone: drop the pair uncounted
                        for (int i = 0; i < 6; i++) begin
                            n_window[i] = win[i+2];
                        end
                        n_fill = 4'd6;
                    end else if (win[4][4:0] != r_burst_type || pd == 16'd0 || pd[0] ||
                                 pd > len_limit) begin
                        // bad type or length: count and drop the pa pair
                        n_rejected = sat_inc(r_rejected);
                        for (int i = 0; i < 6; i++) begin
                            n_window[i] = win[i+2];
                        end
                        n_fill = 4'd6;
                    end else begin
                        n_in_payload = 1'b1;
                        n_left       = pd;
                        n_fill       = 4'd0;
                    end
                end
            end else if (!r_left[0]) begin
                // first byte of a pair is held
                n_held = i_carrier_byte;
                n_left = r_left - 16'd1;
            end else begin
                n_left    = r_left - 16'd1;
                push_pair = 1'b1;
                if (r_left == 16'd1) begin
                    last         = 1'b1;
                    n_in_payload = 1'b0;
                    n_fill       = 4'd0;
                    n_emitted    = sat_inc(r_emitted);
                end
            end
        end
    end

    // swapped pair of result items
    always_comb begin
        res_first.payload_byte    = i_carrier_byte;
        res_first.last_of_burst   = 1'b0;
        res_first.resync_total    = n_resync;
        res_first.rejected_total  = n_rejected;
        res_first.emitted_total   = n_emitted;
        res_second                = res_first;
        res_second.payload_byte   = r_held;
        res_second.last_of_burst  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_in_payload <= 1'b0;
            r_left       <= '0;
            r_held       <= '0;
            r_resync     <= '0;
            r_rejected   <= '0;
            r_emitted    <= '0;
        end else begin
            r_fill       <= n_fill;
            r_in_payload <= n_in_payload;
            r_left       <= n_left;
            r_held       <= n_held;
            r_resync     <= n_resync;
            r_rejected   <= n_rejected;
            r_emitted    <= n_emitted;
        end
    end

    // window bytes beyond the fill point are never read
    always_ff @(posedge i_clk) begin
        r_window <= n_window;
    end

    ibd_result_fifo #(
        .DEPTH (ResultFifoDepth)
    ) u_result_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_pair (push_pair),
        .i_first     (res_first),
        .i_second    (res_second),
        .i_pop       (!i_out_stall),
        .o_head      (head),
        .o_status    (fifo_status)
    );

    assign o_out_valid      = fifo_status.nonempty;
    assign o_payload_byte   = head.payload_byte;
    assign o_last_of_burst  = head.last_of_burst;
    assign o_resync_total   = head.resync_total;
    assign o_rejected_total = head.rejected_total;
    assign o_emitted_total  = head.emitted_total;

`ifndef ASSERT_OFF
    // while hunting the window is never left full
    a_fill_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_payload |-> (r_fill < 4'd8))
        else $error("header window left full while hunting");

    // a burst in progress always has bytes left
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_left != 16'd0))
        else $error("payload phase with no bytes left");

    // the final pair returns to hunting with an empty window
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_in_payload && r_left == 16'd1) |=> (!r_in_payload && r_fill == 4'd0))
        else $error("burst end did not restart hunting");

    // completed burst count never goes down
    a_emitted_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_emitted >= $past(r_emitted)))
        else $error("emitted count decreased");
`endif

endmodule

`default_nettype wire
